// ===== rtl/amck_pkg.sv =====
// shared constants, types and register codes for the admittance integrator
`default_nettype none

package amck_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int TIME_FRAC      = 16;
	localparam int FIELD_W        = 32;
	localparam int GAIN_W         = 32;
	localparam int STEP_W         = 16;
	localparam int NUM_AXES       = 3;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;

	typedef logic [GAIN_W-1:0]  gain_t;
	typedef logic [STEP_W-1:0]  step_t;
	typedef logic [FIELD_W-1:0] field_t;

	localparam logic [CFG_IDX_W-1:0] REG_INV_MASS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPRING    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd3;

	localparam gain_t INV_MASS_RST  = 32'd2184533;
	localparam gain_t DAMPING_RST   = 32'd6554;
	localparam gain_t SPRING_RST    = 32'd0;
	localparam step_t TIME_STEP_RST = 16'd655;

endpackage

`default_nettype wire

// ===== rtl/admittance_mck_integrator.sv =====
// three-axis mass-damper-spring admittance integrator with a bit-serial multiplier
// in_stall stays high until the previous result is registered; the work runs on the shared shift-add multiplier
//   that takes one multiplier bit per cycle, five products per axis, three axes in turn
// a new item is accepted while the previous result still waits on out_stall
// reset: velocity and offset clear to zero, gains return to their defaults, no item pending
`default_nettype none

module admittance_mck_integrator import amck_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [FIELD_W-1:0]    force_x,
	input  wire logic signed [FIELD_W-1:0]    force_y,
	input  wire logic signed [FIELD_W-1:0]    force_z,
	input  wire logic signed [FIELD_W-1:0]    pose_x,
	input  wire logic signed [FIELD_W-1:0]    pose_y,
	input  wire logic signed [FIELD_W-1:0]    pose_z,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [FIELD_W-1:0]         target_x,
	output logic signed [FIELD_W-1:0]         target_y,
	output logic signed [FIELD_W-1:0]         target_z,
	output logic                              saturated,
	input  wire logic                         cfg_write,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int DW  = DATA_WIDTH;
	localparam int EW  = DW + 1;
	localparam int IW  = ((DW > FIELD_W + 1) ? DW : FIELD_W + 1) + 1;
	localparam int TW  = (DW > FIELD_W) ? DW : FIELD_W;
	localparam int HW  = GAIN_W + 1;
	localparam int PW  = DW + GAIN_W;
	localparam int PW1 = PW + 1;
	localparam int CW  = $clog2(DW + 1);

	localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
	localparam field_t OUT_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam field_t OUT_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
	localparam logic [PW:0] RND_F   = PW1'(1) << (FRAC_BITS - 1);
	localparam logic [PW:0] RND_T   = PW1'(1) << (TIME_FRAC - 1);
	localparam logic [PW:0] LIM_POS = PW1'(MAXV);
	localparam logic [1:0]  AXIS_LAST = 2'(NUM_AXES - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RUN  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_RND  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	localparam logic [3:0] PH_DV   = 4'd0;
	localparam logic [3:0] PH_NET1 = 4'd1;
	localparam logic [3:0] PH_KP   = 4'd2;
	localparam logic [3:0] PH_NET2 = 4'd3;
	localparam logic [3:0] PH_ACC  = 4'd4;
	localparam logic [3:0] PH_DVEL = 4'd5;
	localparam logic [3:0] PH_VEL  = 4'd6;
	localparam logic [3:0] PH_DPOS = 4'd7;
	localparam logic [3:0] PH_POS  = 4'd8;

	function automatic logic add_ovf(input logic signed [EW-1:0] x);
		return x[EW-1] != x[EW-2];
	endfunction

	function automatic logic signed [DW-1:0] add_sat(input logic signed [EW-1:0] x);
		logic signed [DW-1:0] y;
		if (x[EW-1] != x[EW-2]) begin
			y = x[EW-1] ? MINV : MAXV;
		end else begin
			y = x[DW-1:0];
		end
		return y;
	endfunction

	function automatic logic in_ovf(input logic signed [IW-1:0] x);
		logic [IW-DW:0] top;
		top = x[IW-1:DW-1];
		return !((&top) || !(|top));
	endfunction

	function automatic logic signed [DW-1:0] in_sat(input logic signed [IW-1:0] x);
		logic signed [DW-1:0] y;
		if (in_ovf(x)) begin
			y = x[IW-1] ? MINV : MAXV;
		end else begin
			y = x[DW-1:0];
		end
		return y;
	endfunction

	function automatic logic out_ovf(input logic signed [TW-1:0] x);
		logic [TW-FIELD_W:0] top;
		top = x[TW-1:FIELD_W-1];
		return !((&top) || !(|top));
	endfunction

	function automatic field_t out_sat(input logic signed [TW-1:0] x);
		field_t y;
		if (out_ovf(x)) begin
			y = x[TW-1] ? OUT_MIN : OUT_MAX;
		end else begin
			y = x[FIELD_W-1:0];
		end
		return y;
	endfunction

	// configuration
	gain_t inv_mass_q, damping_q, spring_q;
	step_t time_step_q;

	// control
	logic [2:0]    state_q;
	logic [3:0]    ph_q;
	logic [1:0]    axis_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;

	// integrator state
	logic signed [DW-1:0] vel_q [NUM_AXES];
	logic signed [DW-1:0] off_q [NUM_AXES];

	// datapath
	logic signed [DW-1:0] force_q [NUM_AXES];
	logic signed [DW-1:0] pose_q [NUM_AXES];
	logic signed [DW-1:0] t_q, mres_q;
	logic [PW:0]          prod_q;
	logic                 neg_q, tsel_q, sat_q;
	gain_t                b_q;
	field_t               tgt_q [NUM_AXES];
	logic                 sat_out_q;

	// input capture with remap x <- fy, y <- fx, z <- -fz
	logic signed [IW-1:0] in_f_e [NUM_AXES];
	logic signed [IW-1:0] in_p_e [NUM_AXES];
	logic signed [DW-1:0] in_f [NUM_AXES];
	logic signed [DW-1:0] in_p [NUM_AXES];
	logic                 in_clip;

	always_comb begin
		in_f_e[0] = IW'(force_y);
		in_f_e[1] = IW'(force_x);
		in_f_e[2] = -IW'(force_z);
		in_p_e[0] = IW'(pose_x);
		in_p_e[1] = IW'(pose_y);
		in_p_e[2] = IW'(pose_z);
		in_clip = 1'b0;
		for (int i = 0; i < NUM_AXES; i++) begin
			in_f[i] = in_sat(in_f_e[i]);
			in_p[i] = in_sat(in_p_e[i]);
			in_clip = in_clip | in_ovf(in_f_e[i]) | in_ovf(in_p_e[i]);
		end
	end

	// phase decode
	logic signed [DW-1:0] v_cur, p_cur, f_cur;
	logic signed [DW-1:0] mul_a, add_x, add_y;
	gain_t                mul_b;
	logic                 mul_t, is_mul, is_add, add_sub;
	logic [3:0]           ph_nxt;

	always_comb begin
		v_cur = vel_q[axis_q];
		p_cur = off_q[axis_q];
		f_cur = force_q[axis_q];
		mul_a = v_cur;
		mul_b = damping_q;
		mul_t = 1'b0;
		is_mul = 1'b0;
		is_add = 1'b0;
		add_sub = 1'b0;
		add_x = v_cur;
		add_y = mres_q;
		ph_nxt = PH_DV;
		unique case (ph_q)
			PH_DV: begin
				is_mul = 1'b1;
				ph_nxt = PH_NET1;
			end
			PH_NET1: begin
				is_add = 1'b1;
				add_sub = 1'b1;
				add_x = f_cur;
				ph_nxt = PH_KP;
			end
			PH_KP: begin
				is_mul = 1'b1;
				mul_a = p_cur;
				mul_b = spring_q;
				ph_nxt = PH_NET2;
			end
			PH_NET2: begin
				is_add = 1'b1;
				add_sub = 1'b1;
				add_x = t_q;
				ph_nxt = PH_ACC;
			end
			PH_ACC: begin
				is_mul = 1'b1;
				mul_a = t_q;
				mul_b = inv_mass_q;
				ph_nxt = PH_DVEL;
			end
			PH_DVEL: begin
				is_mul = 1'b1;
				mul_a = mres_q;
				mul_b = GAIN_W'(time_step_q);
				mul_t = 1'b1;
				ph_nxt = PH_VEL;
			end
			PH_VEL: begin
				is_add = 1'b1;
				ph_nxt = PH_DPOS;
			end
			PH_DPOS: begin
				is_mul = 1'b1;
				mul_b = GAIN_W'(time_step_q);
				mul_t = 1'b1;
				ph_nxt = PH_POS;
			end
			PH_POS: begin
				is_add = 1'b1;
				add_x = p_cur;
				ph_nxt = PH_DV;
			end
			default: begin
				ph_nxt = PH_DV;
			end
		endcase
	end

	// saturating adder
	logic signed [EW-1:0] add_e;
	logic signed [DW-1:0] add_res;
	logic                 add_clip;

	always_comb begin
		add_e = add_sub ? (EW'(add_x) - EW'(add_y)) : (EW'(add_x) + EW'(add_y));
		add_res = add_sat(add_e);
		add_clip = add_ovf(add_e);
	end

	// shift-add multiplier: one multiplier bit per cycle into an accumulator one bit wider than the gain
	logic              mul_neg;
	logic [DW-1:0]     mul_mag;
	logic [HW-1:0]     acc_sum;
	logic [PW:0]       step_d;

	always_comb begin
		mul_neg = mul_a[DW-1];
		mul_mag = mul_neg ? (~mul_a + 1'b1) : mul_a;
		acc_sum = prod_q[PW:DW] + (prod_q[0] ? HW'(b_q) : HW'(0));
		step_d = {1'b0, acc_sum, prod_q[DW-1:1]};
	end

	// round half away from zero, drop the fraction, clamp the magnitude
	logic [PW:0]          rsum, rq, rlim, rqc;
	logic                 rnd_clip;
	logic [DW-1:0]        rmag;
	logic signed [DW-1:0] mres_d;

	always_comb begin
		rsum = {1'b0, prod_q[PW-1:0]} + (tsel_q ? RND_T : RND_F);
		rq = tsel_q ? (rsum >> TIME_FRAC) : (rsum >> FRAC_BITS);
		rlim = LIM_POS + PW1'(neg_q);
		rnd_clip = rq > rlim;
		rqc = rnd_clip ? rlim : rq;
		rmag = rqc[DW-1:0];
		mres_d = neg_q ? (~rmag + 1'b1) : rmag;
	end

	// targets from pose and new offsets
	logic signed [EW-1:0] fin_e [NUM_AXES];
	logic signed [TW-1:0] fin_t [NUM_AXES];
	field_t               fin_tgt [NUM_AXES];
	logic                 fin_clip;

	always_comb begin
		fin_clip = 1'b0;
		for (int i = 0; i < NUM_AXES; i++) begin
			fin_e[i] = EW'(pose_q[i]) + EW'(off_q[i]);
			fin_t[i] = TW'(add_sat(fin_e[i]));
			fin_tgt[i] = out_sat(fin_t[i]);
			fin_clip = fin_clip | add_ovf(fin_e[i]) | out_ovf(fin_t[i]);
		end
	end

	logic take_in, mul_go, add_go, rnd_go, fin_go;

	always_comb begin
		take_in = (state_q == ST_IDLE) && in_valid;
		mul_go = (state_q == ST_RUN) && is_mul;
		add_go = (state_q == ST_RUN) && is_add;
		rnd_go = (state_q == ST_RND);
		fin_go = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q <= INV_MASS_RST;
			damping_q <= DAMPING_RST;
			spring_q <= SPRING_RST;
			time_step_q <= TIME_STEP_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_INV_MASS:  inv_mass_q <= cfg_data;
				REG_DAMPING:   damping_q <= cfg_data;
				REG_SPRING:    spring_q <= cfg_data;
				REG_TIME_STEP: time_step_q <= cfg_data[STEP_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q <= PH_DV;
			axis_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_AXES; i++) begin
				vel_q[i] <= '0;
				off_q[i] <= '0;
			end
		end else begin
			// a new result replacing the one taken this cycle keeps valid high
			if (out_valid_q && !out_stall && !fin_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take_in) begin
						axis_q <= '0;
						ph_q <= PH_DV;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					ph_q <= ph_nxt;
					if (is_mul) begin
						cnt_q <= CW'(DW);
						state_q <= ST_MUL;
					end
					if (ph_q == PH_VEL) begin
						vel_q[axis_q] <= add_res;
					end
					if (ph_q == PH_POS) begin
						off_q[axis_q] <= add_res;
						if (axis_q == AXIS_LAST) begin
							state_q <= ST_FIN;
						end else begin
							axis_q <= axis_q + 2'd1;
						end
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					state_q <= ST_RUN;
				end
				ST_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				force_q[i] <= in_f[i];
				pose_q[i] <= in_p[i];
			end
		end
		if (mul_go) begin
			prod_q <= PW1'(mul_mag);
			neg_q <= mul_neg;
			b_q <= mul_b;
			tsel_q <= mul_t;
		end else if (state_q == ST_MUL) begin
			prod_q <= step_d;
		end
		if (rnd_go) begin
			mres_q <= mres_d;
		end
		if (add_go && (ph_q == PH_NET1 || ph_q == PH_NET2)) begin
			t_q <= add_res;
		end
		priority if (take_in) begin
			sat_q <= in_clip;
		end else if (rnd_go) begin
			sat_q <= sat_q | rnd_clip;
		end else if (add_go) begin
			sat_q <= sat_q | add_clip;
		end
		if (fin_go) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				tgt_q[i] <= fin_tgt[i];
			end
			sat_out_q <= sat_q | fin_clip;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign target_x = tgt_q[0];
	assign target_y = tgt_q[1];
	assign target_z = tgt_q[2];
	assign saturated = sat_out_q;

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside the final step");

	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (cnt_q != '0 && cnt_q <= CW'(DW)))
		else $error("multiplier bit count out of range");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_RUN && ph_q == PH_DV && axis_q == '0))
		else $error("accepted item did not start at the first axis");

endmodule

`default_nettype wire
